// ===== rtl/core/lcwf_pkg.sv =====
package lcwf_pkg;

  // Field and datapath widths fixed by the data formats.
  localparam int RAW_W     = 24;
  localparam int AVG_W     = 24;
  localparam int WGT_W     = 36;
  localparam int CAL_W     = 24;
  localparam int LIM_W     = 16;
  localparam int DZ_W      = 21;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  // Tenths of a gram of a 36-bit Q.10 weight fit in 30 signed bits.
  localparam int TEN_W = 30;

  // Shared divider: 42-bit dividend, 24-bit divisor, up to 42 iterations.
  localparam int DIV_W  = 42;
  localparam int DIVR_W = 24;
  localparam int ITER_W = 6;

  // Average minus tare is shifted by this amount before the calibration divide.
  localparam int SCALE_SHIFT = 18;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_LIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 2'd2;

  // Register values after reset.
  localparam logic [CAL_W-1:0] CAL_RESET = 24'd537600;
  localparam logic [LIM_W-1:0] LIM_RESET = 16'd150;
  localparam logic [DZ_W-1:0]  DZ_RESET  = 21'd2048;

  // Result kind codes.
  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_TARE   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AVG,
    S_AVG_WAIT,
    S_SCALE,
    S_SCALE_WAIT,
    S_DEAD,
    S_TENTHS,
    S_SPIKE,
    S_EMIT
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  // Response of the shared divider.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Q.10 grams to tenths of a gram, truncated toward zero.
  function automatic logic signed [TEN_W-1:0] tenths(input logic signed [WGT_W-1:0] w);
    logic [WGT_W-1:0] mag;
    logic [WGT_W+3:0] prod;
    logic [TEN_W-1:0] quo;
    mag  = w[WGT_W-1] ? WGT_W'(-w) : w;
    prod = ({4'b0, mag} << 3) + ({4'b0, mag} << 1);
    quo  = prod[TEN_W+9:10];
    return w[WGT_W-1] ? (TEN_W'(0) - quo) : quo;
  endfunction

endpackage

// ===== rtl/core/lcwf_in_if.sv =====
interface lcwf_in_if;
  logic                       valid;
  logic                       ready;
  logic [lcwf_pkg::RAW_W-1:0] raw_word;
  logic                       read_ok;
  logic                       tare_group;
  logic                       last_in_group;

  modport source (output valid, raw_word, read_ok, tare_group, last_in_group, input ready);
  modport sink   (input valid, raw_word, read_ok, tare_group, last_in_group, output ready);
endinterface

// ===== rtl/core/lcwf_out_if.sv =====
interface lcwf_out_if;
  logic                              valid;
  logic                              ready;
  logic                              result_kind;
  logic                              success;
  logic signed [lcwf_pkg::WGT_W-1:0] weight_q10;
  logic                              spike_held;
  logic signed [lcwf_pkg::AVG_W-1:0] average;

  modport source (output valid, result_kind, success, weight_q10, spike_held, average,
                  input ready);
  modport sink   (input valid, result_kind, success, weight_q10, spike_held, average,
                  output ready);
endinterface

// ===== rtl/core/lcwf_cfg_if.sv =====
interface lcwf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lcwf_pkg::CFG_IDX_W-1:0] index;
  logic [lcwf_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/load_cell_weigh_filter_top.sv =====
// Load-cell weigh filter.
// Input channel "samples": one word per converter reading (raw 24-bit value, a good-read
// flag, the group kind and an end-of-group mark). Output channel "results": one word per
// finished group with the kind, a success flag, the Q.10 weight, a spike flag and the
// group average. Channel "cfg" writes the calibration factor, spike limit and dead zone;
// it is always ready and should only be used while no group result is pending.
// A word that does not close a group leaves the block ready, so such words stream at one
// per cycle. A group closes on the end mark or on its MAX_GROUP-th word; from that word
// until its result is loaded the block is not ready. Closing words run through one shared
// restoring divider at one quotient bit per cycle: the average takes 24 + clog2(MAX_GROUP)
// steps, the calibration scaling 42 steps. A tare group's result follows the average divide;
// a weigh group's follows the scaling divide and the dead-zone, tenths and spike steps;
// either is loaded when the output register is free. A group with no good reading skips
// the divider and reports failure once the output register is free.
// The result sits in an output register; if the receiver stalls, the block waits with
// the next result until that register is free and takes no input meanwhile.
// Reset clears the running sum, counts, tare offset and last weight, and restores the
// register defaults.
module load_cell_weigh_filter_top #(
  parameter int MAX_GROUP = 32
) (
  input  logic        clk,
  input  logic        rst,
  lcwf_in_if.sink     samples,
  lcwf_out_if.source  results,
  lcwf_cfg_if.sink    cfg
);
  import lcwf_pkg::*;

  localparam int SumW     = RAW_W + $clog2(MAX_GROUP);
  localparam int CntW     = $clog2(MAX_GROUP + 1);
  localparam int AvgShift = DIV_W - SumW;

  state_t state, state_next;

  // Configuration registers.
  logic [CAL_W-1:0] cal_factor_q8;
  logic [LIM_W-1:0] spike_limit;
  logic [DZ_W-1:0]  dead_zone_q10;

  // Group and filter state.
  logic signed [SumW-1:0]  sample_sum;
  logic [CntW-1:0]         samples_seen;
  logic [CntW-1:0]         good_count;
  logic                    is_tare;
  logic                    group_ok;
  logic signed [AVG_W-1:0] avg;
  logic signed [AVG_W-1:0] tare_value;
  logic signed [WGT_W-1:0] last_weight;
  logic signed [WGT_W-1:0] weight;
  logic                    held;
  logic signed [TEN_W-1:0] ten_new;
  logic signed [TEN_W-1:0] ten_last;

  // Output register.
  logic                    out_valid;
  logic                    out_kind;
  logic                    out_success;
  logic signed [WGT_W-1:0] out_weight;
  logic                    out_held;
  logic signed [AVG_W-1:0] out_average;

  // Datapath helpers.
  logic                    in_acc;
  logic                    emit_load;
  logic                    group_end;
  logic signed [SumW-1:0]  sample_ext;
  logic signed [SumW-1:0]  sum_acc;
  logic [CntW-1:0]         good_acc;
  logic [SumW-1:0]         sum_mag;
  logic signed [AVG_W:0]   diff;
  logic [AVG_W-1:0]        diff_mag;
  logic [CAL_W-1:0]        cal_eff;
  logic signed [WGT_W-1:0] weight_sat;
  logic signed [WGT_W:0]   neg_dz;
  logic signed [TEN_W:0]   ten_diff;
  logic [TEN_W:0]          ten_mag;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  lcwf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Handshakes.
  assign cfg.ready     = 1'b1;
  assign samples.ready = (state == S_IDLE);
  assign in_acc        = samples.valid && samples.ready;
  assign emit_load     = (state == S_EMIT) && (!out_valid || results.ready);

  // Accumulation of one incoming word.
  assign sample_ext = SumW'($signed(samples.raw_word));
  assign sum_acc    = samples.read_ok ? sample_sum + sample_ext : sample_sum;
  assign good_acc   = good_count + CntW'(samples.read_ok);
  assign group_end  = samples.last_in_group || (samples_seen == CntW'(MAX_GROUP - 1));

  // Operand magnitudes for the divider.
  assign sum_mag  = sample_sum[SumW-1] ? SumW'(-sample_sum) : sample_sum;
  assign diff     = {avg[AVG_W-1], avg} - {tare_value[AVG_W-1], tare_value};
  assign diff_mag = diff[AVG_W] ? AVG_W'(-diff) : diff[AVG_W-1:0];
  assign cal_eff  = (cal_factor_q8 == '0) ? CAL_W'(1) : cal_factor_q8;

  // Saturate the scaled quotient to the signed weight range.
  always_comb begin
    if (div_rsp.quotient[DIV_W-1:WGT_W-1] != '0) begin
      weight_sat = diff[AVG_W] ? {1'b1, {(WGT_W-1){1'b0}}} : {1'b0, {(WGT_W-1){1'b1}}};
    end else if (diff[AVG_W]) begin
      weight_sat = WGT_W'(0) - {1'b0, div_rsp.quotient[WGT_W-2:0]};
    end else begin
      weight_sat = {1'b0, div_rsp.quotient[WGT_W-2:0]};
    end
  end

  assign neg_dz   = (WGT_W + 1)'(0) - {{(WGT_W + 1 - DZ_W){1'b0}}, dead_zone_q10};
  assign ten_diff = {ten_new[TEN_W-1], ten_new} - {ten_last[TEN_W-1], ten_last};
  assign ten_mag  = ten_diff[TEN_W] ? (TEN_W + 1)'(-ten_diff) : ten_diff;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and divider requests.
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.iters    = ITER_W'(SumW);
    div_req.dividend = DIV_W'(sum_mag) << AvgShift;
    div_req.divisor  = DIVR_W'(good_count);
    unique case (state)
      S_IDLE: begin
        if (in_acc && group_end) begin
          state_next = (good_acc != '0) ? S_AVG : S_EMIT;
        end
      end
      S_AVG: begin
        div_req.start = 1'b1;
        state_next    = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (div_rsp.done) begin
          state_next = is_tare ? S_EMIT : S_SCALE;
        end
      end
      S_SCALE: begin
        div_req.start    = 1'b1;
        div_req.iters    = ITER_W'(DIV_W);
        div_req.dividend = {diff_mag, {SCALE_SHIFT{1'b0}}};
        div_req.divisor  = cal_eff;
        state_next       = S_SCALE_WAIT;
      end
      S_SCALE_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_DEAD;
        end
      end
      S_DEAD:   state_next = S_TENTHS;
      S_TENTHS: state_next = S_SPIKE;
      S_SPIKE:  state_next = S_EMIT;
      S_EMIT: begin
        if (emit_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_factor_q8 <= CAL_RESET;
      spike_limit   <= LIM_RESET;
      dead_zone_q10 <= DZ_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_CAL_FACTOR: cal_factor_q8 <= cfg.data;
        CFG_SPIKE_LIM:  spike_limit   <= cfg.data[LIM_W-1:0];
        CFG_DEAD_ZONE:  dead_zone_q10 <= cfg.data[DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Group accumulation and persistent filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      samples_seen <= '0;
      good_count   <= '0;
      tare_value   <= '0;
      last_weight  <= '0;
    end else if (in_acc) begin
      sample_sum   <= sum_acc;
      good_count   <= good_acc;
      samples_seen <= group_end ? '0 : samples_seen + CntW'(1);
    end else if (emit_load) begin
      sample_sum <= '0;
      good_count <= '0;
      if (group_ok && is_tare) begin
        tare_value <= avg;
      end else if (group_ok) begin
        last_weight <= weight;
      end
    end
  end

  // Per-group working registers.
  always_ff @(posedge clk) begin
    if (in_acc && group_end) begin
      is_tare  <= samples.tare_group;
      group_ok <= (good_acc != '0);
      held     <= 1'b0;
    end
    if (state == S_AVG_WAIT && div_rsp.done) begin
      avg <= sample_sum[SumW-1] ? AVG_W'(0) - div_rsp.quotient[AVG_W-1:0]
                                : div_rsp.quotient[AVG_W-1:0];
    end
    if (state == S_SCALE_WAIT && div_rsp.done) begin
      weight <= weight_sat;
    end
    // Readings just below zero read as zero.
    if (state == S_DEAD && weight[WGT_W-1] &&
        ($signed({weight[WGT_W-1], weight}) > neg_dz)) begin
      weight <= '0;
    end
    if (state == S_TENTHS) begin
      ten_new  <= tenths(weight);
      ten_last <= tenths(last_weight);
    end
    // A jump beyond the limit repeats the last weight.
    if (state == S_SPIKE && ten_mag > (TEN_W + 1)'(spike_limit)) begin
      weight <= last_weight;
      held   <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_kind    <= is_tare ? KIND_TARE : KIND_WEIGHT;
      out_success <= group_ok;
      out_average <= group_ok ? avg : '0;
      out_weight  <= (group_ok && !is_tare) ? weight : '0;
      out_held    <= group_ok && !is_tare && held;
    end
  end

  assign results.valid       = out_valid;
  assign results.result_kind = out_kind;
  assign results.success     = out_success;
  assign results.weight_q10  = out_weight;
  assign results.spike_held  = out_held;
  assign results.average     = out_average;

endmodule

// ===== rtl/core/lcwf_div.sv =====
module lcwf_div (
  input  logic               clk,
  input  logic               rst,
  input  lcwf_pkg::div_req_t req,
  output lcwf_pkg::div_rsp_t rsp
);
  import lcwf_pkg::*;

  logic              busy;
  logic              done;
  logic [ITER_W-1:0] cnt;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] dvs;
  logic [DIV_W-1:0]  quo;
  logic [DIVR_W:0]   trial;
  logic              fits;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.iters;
      end else if (busy) begin
        cnt <= cnt - ITER_W'(1);
        if (cnt == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register; the dividend shifts out as quotient bits enter.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? DIVR_W'(trial - {1'b0, dvs}) : trial[DIVR_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
